FILE: sv/mcu_instruction_decoder_defines.svh
// Assertion macros used by the top-level decoder module.
// No dependencies.
`ifndef MCU_INSTRUCTION_DECODER_DEFINES_SVH
`define MCU_INSTRUCTION_DECODER_DEFINES_SVH
// a implies b on the same edge
`define MID_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b on the next edge
`define MID_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: sv/mid_pkg.sv
// Package for the instruction decoder: mnemonic codes and stage types.
// No dependencies.
package mid_pkg;
  typedef enum logic [6:0] {
    M_INVALID, M_NOP, M_MOVW, M_MULS, M_MULSU, M_FMUL, M_FMULS, M_FMULSU,
    M_CPC, M_SBC, M_ADD, M_CPSE, M_CP, M_SUB, M_ADC, M_AND, M_EOR, M_OR,
    M_MOV, M_CPI, M_SBCI, M_SUBI, M_ORI, M_ANDI, M_LDD, M_STD, M_LDS, M_LD,
    M_LPM, M_ELPM, M_POP, M_STS, M_ST, M_XCH, M_LAS, M_LAC, M_LAT, M_PUSH,
    M_BSET, M_BCLR, M_IJMP, M_EIJMP, M_RET, M_ICALL, M_RETI, M_EICALL,
    M_SLEEP, M_BREAK, M_WDR, M_SPM, M_COM, M_NEG, M_SWAP, M_INC, M_ASR,
    M_LSR, M_ROR, M_DEC, M_DES, M_JMP, M_CALL, M_ADIW, M_SBIW, M_CBI,
    M_SBIC, M_SBI, M_SBIS, M_MUL, M_IN, M_OUT, M_RJMP, M_RCALL, M_LDI,
    M_BRBS, M_BRBC, M_BLD, M_BST, M_SBRC, M_SBRS
  } mnem_t;

  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_X    = 2'd1;
  localparam logic [1:0] P_Y    = 2'd2;
  localparam logic [1:0] P_Z    = 2'd3;

  typedef enum logic [3:0] {
    G_ZERO, G_RR, G_RI, G_LDD, G_LS, G_MISC, G_IO, G_MUL, G_INOUT, G_RJ,
    G_BR, G_BLDST, G_SBR
  } grp_t;

  typedef struct packed {
    logic        vld;
    grp_t        grp;
    logic [15:0] w;
    logic [15:0] w2;
  } cls_t;

  typedef struct packed {
    logic        vld;
    mnem_t       mn;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [7:0]  imm;
    logic [5:0]  io;
    logic [2:0]  bit_i;
    logic [11:0] rel;
    logic [22:0] addr;
    logic [1:0]  ptr;
    logic [1:0]  mode;
    logic        brc;
    logic        two;
  } dec_t;
endpackage

FILE: sv/mid_classify.sv
// Stage 1: registers the input item and its opcode group.
// Depends on mid_pkg.
module mid_classify import mid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  logic [15:0] w_i,
  input  logic [15:0] w2_i,
  output cls_t        cls_o
);
  cls_t cls_r, cls_nxt;

  always_comb begin
    cls_nxt.vld = vld_i;
    cls_nxt.w   = w_i;
    cls_nxt.w2  = w2_i;
    if (w_i[15:10] == 6'd0) cls_nxt.grp = G_ZERO;
    else if (w_i[15:10] <= 6'd11) cls_nxt.grp = G_RR;
    else begin
      case (w_i[15:12])
        4'h8, 4'ha: cls_nxt.grp = G_LDD;
        4'h9: begin
          case (w_i[11:10])
            2'd0: cls_nxt.grp = G_LS;
            2'd1: cls_nxt.grp = G_MISC;
            2'd2: cls_nxt.grp = G_IO;
            default: cls_nxt.grp = G_MUL;
          endcase
        end
        4'hb: cls_nxt.grp = G_INOUT;
        4'hc, 4'hd: cls_nxt.grp = G_RJ;
        4'hf: begin
          case (w_i[11:10])
            2'd0, 2'd1: cls_nxt.grp = G_BR;
            2'd2: cls_nxt.grp = G_BLDST;
            default: cls_nxt.grp = G_SBR;
          endcase
        end
        default: cls_nxt.grp = G_RI;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r.vld <= 1'b0;
    end else begin
      cls_r.vld <= cls_nxt.vld;
    end
    cls_r.grp <= cls_nxt.grp;
    cls_r.w   <= cls_nxt.w;
    cls_r.w2  <= cls_nxt.w2;
  end

  assign cls_o = cls_r;
endmodule

FILE: sv/mid_decode.sv
// Stage 2: decodes mnemonic and operand fields within the group.
// Depends on mid_pkg.
module mid_decode import mid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cls_t cls_i,
  output dec_t dec_o
);
  dec_t dec_r, dec_nxt;
  logic [15:0] w;
  logic [4:0]  d5, r5;

  assign w  = cls_i.w;
  assign d5 = w[8:4];
  assign r5 = {w[9], w[3:0]};

  always_comb begin
    dec_nxt       = '0;
    dec_nxt.vld   = cls_i.vld;
    dec_nxt.mn    = M_INVALID;
    case (cls_i.grp)
      G_ZERO: begin
        if (w == 16'h0000) dec_nxt.mn = M_NOP;
        else if (w[15:8] == 8'h01) begin
          dec_nxt.mn = M_MOVW; dec_nxt.ra = {w[7:4], 1'b0}; dec_nxt.rb = {w[3:0], 1'b0};
        end else if (w[15:8] == 8'h02) begin
          dec_nxt.mn = M_MULS; dec_nxt.ra = {1'b1, w[7:4]}; dec_nxt.rb = {1'b1, w[3:0]};
        end else if (w[15:8] == 8'h03) begin
          case ({w[7], w[3]})
            2'd0: dec_nxt.mn = M_MULSU;
            2'd1: dec_nxt.mn = M_FMUL;
            2'd2: dec_nxt.mn = M_FMULS;
            default: dec_nxt.mn = M_FMULSU;
          endcase
          dec_nxt.ra = {2'b10, w[6:4]}; dec_nxt.rb = {2'b10, w[2:0]};
        end
      end
      G_RR: begin
        case (w[13:10])
          4'd1: dec_nxt.mn = M_CPC;
          4'd2: dec_nxt.mn = M_SBC;
          4'd3: dec_nxt.mn = M_ADD;
          4'd4: dec_nxt.mn = M_CPSE;
          4'd5: dec_nxt.mn = M_CP;
          4'd6: dec_nxt.mn = M_SUB;
          4'd7: dec_nxt.mn = M_ADC;
          4'd8: dec_nxt.mn = M_AND;
          4'd9: dec_nxt.mn = M_EOR;
          4'd10: dec_nxt.mn = M_OR;
          default: dec_nxt.mn = M_MOV;
        endcase
        dec_nxt.ra = d5; dec_nxt.rb = r5;
      end
      G_RI: begin
        case (w[15:12])
          4'h3: dec_nxt.mn = M_CPI;
          4'h4: dec_nxt.mn = M_SBCI;
          4'h5: dec_nxt.mn = M_SUBI;
          4'h6: dec_nxt.mn = M_ORI;
          4'h7: dec_nxt.mn = M_ANDI;
          default: dec_nxt.mn = M_LDI;
        endcase
        dec_nxt.ra = {1'b1, w[7:4]}; dec_nxt.imm = {w[11:8], w[3:0]};
      end
      G_LDD: begin
        dec_nxt.mn  = w[9] ? M_STD : M_LDD;
        dec_nxt.ra  = d5;
        dec_nxt.imm = {2'b00, w[13], w[11:10], w[2:0]};
        dec_nxt.ptr = w[3] ? P_Y : P_Z;
      end
      G_LS: begin
        // reserved slots keep the register field
        dec_nxt.ra = d5;
        case (w[3:0])
          4'h0: begin
            dec_nxt.mn = w[9] ? M_STS : M_LDS;
            dec_nxt.addr = {7'd0, cls_i.w2}; dec_nxt.two = 1'b1;
          end
          4'h1, 4'h2: begin
            dec_nxt.mn = w[9] ? M_ST : M_LD; dec_nxt.ptr = P_Z; dec_nxt.mode = w[1:0];
          end
          4'h9, 4'ha: begin
            dec_nxt.mn = w[9] ? M_ST : M_LD; dec_nxt.ptr = P_Y; dec_nxt.mode = w[1:0];
          end
          4'hc, 4'hd, 4'he: begin
            dec_nxt.mn = w[9] ? M_ST : M_LD; dec_nxt.ptr = P_X; dec_nxt.mode = w[1:0];
          end
          4'hf: dec_nxt.mn = w[9] ? M_PUSH : M_POP;
          4'h4, 4'h5, 4'h6, 4'h7: begin
            dec_nxt.ptr = P_Z;
            if (w[9]) begin
              case (w[1:0])
                2'd0: dec_nxt.mn = M_XCH;
                2'd1: dec_nxt.mn = M_LAS;
                2'd2: dec_nxt.mn = M_LAC;
                default: dec_nxt.mn = M_LAT;
              endcase
            end else begin
              dec_nxt.mn = w[1] ? M_ELPM : M_LPM;
              dec_nxt.mode = {1'b0, w[0]};
            end
          end
          default: dec_nxt.mn = M_INVALID;
        endcase
      end
      G_MISC: begin
        if ((w & 16'h020e) == 16'h0008) begin
          if ((w & 16'hff8f) == 16'h9408) begin
            dec_nxt.mn = M_BSET; dec_nxt.bit_i = w[6:4];
          end else if ((w & 16'hff8f) == 16'h9488) begin
            dec_nxt.mn = M_BCLR; dec_nxt.bit_i = w[6:4];
          end else begin
            case (w)
              16'h9409: dec_nxt.mn = M_IJMP;
              16'h9419: dec_nxt.mn = M_EIJMP;
              16'h9508: dec_nxt.mn = M_RET;
              16'h9509: dec_nxt.mn = M_ICALL;
              16'h9518: dec_nxt.mn = M_RETI;
              16'h9519: dec_nxt.mn = M_EICALL;
              16'h9588: dec_nxt.mn = M_SLEEP;
              16'h9598: dec_nxt.mn = M_BREAK;
              16'h95a8: dec_nxt.mn = M_WDR;
              16'h95c8: begin dec_nxt.mn = M_LPM; dec_nxt.ptr = P_Z; end
              16'h95d8: begin dec_nxt.mn = M_ELPM; dec_nxt.ptr = P_Z; end
              16'h95e8: dec_nxt.mn = M_SPM;
              16'h95f8: begin
                dec_nxt.mn = M_SPM; dec_nxt.ptr = P_Z; dec_nxt.mode = 2'd1;
              end
              default: dec_nxt.mn = M_INVALID;
            endcase
          end
        end else if (!w[9]) begin
          if (w[3:2] == 2'b11) begin
            dec_nxt.mn = w[1] ? M_CALL : M_JMP;
            dec_nxt.addr = {w[8:4], w[0], cls_i.w2, 1'b0};
            dec_nxt.two = 1'b1;
          end else if (w[3:0] == 4'hb) begin
            if (!w[8]) begin dec_nxt.mn = M_DES; dec_nxt.imm = {4'd0, w[7:4]}; end
          end else begin
            case (w[3:0])
              4'h0: dec_nxt.mn = M_COM;
              4'h1: dec_nxt.mn = M_NEG;
              4'h2: dec_nxt.mn = M_SWAP;
              4'h3: dec_nxt.mn = M_INC;
              4'h5: dec_nxt.mn = M_ASR;
              4'h6: dec_nxt.mn = M_LSR;
              4'h7: dec_nxt.mn = M_ROR;
              4'ha: dec_nxt.mn = M_DEC;
              default: dec_nxt.mn = M_INVALID;
            endcase
            if (dec_nxt.mn != M_INVALID) dec_nxt.ra = d5;
          end
        end else begin
          dec_nxt.mn  = w[8] ? M_SBIW : M_ADIW;
          dec_nxt.ra  = {2'b11, w[5:4], 1'b0};
          dec_nxt.imm = {2'b00, w[7:6], w[3:0]};
        end
      end
      G_IO: begin
        case (w[9:8])
          2'd0: dec_nxt.mn = M_CBI;
          2'd1: dec_nxt.mn = M_SBIC;
          2'd2: dec_nxt.mn = M_SBI;
          default: dec_nxt.mn = M_SBIS;
        endcase
        dec_nxt.io = {1'b0, w[7:3]}; dec_nxt.bit_i = w[2:0];
      end
      G_MUL: begin
        dec_nxt.mn = M_MUL; dec_nxt.ra = d5; dec_nxt.rb = r5;
      end
      G_INOUT: begin
        dec_nxt.mn = w[11] ? M_OUT : M_IN;
        dec_nxt.ra = d5; dec_nxt.io = {w[10:9], w[3:0]};
      end
      G_RJ: begin
        dec_nxt.mn = w[12] ? M_RCALL : M_RJMP;
        dec_nxt.rel = w[11:0];
      end
      G_BR: begin
        dec_nxt.brc = w[10];
        dec_nxt.mn  = w[10] ? M_BRBC : M_BRBS;
        dec_nxt.bit_i = w[2:0];
        dec_nxt.rel = {{5{w[9]}}, w[9:3]};
      end
      G_BLDST: begin
        if (!w[3]) begin
          dec_nxt.mn = w[9] ? M_BST : M_BLD; dec_nxt.ra = d5; dec_nxt.bit_i = w[2:0];
        end
      end
      G_SBR: begin
        if (!w[3]) begin
          dec_nxt.mn = w[9] ? M_SBRS : M_SBRC; dec_nxt.ra = d5; dec_nxt.bit_i = w[2:0];
        end
      end
      default: dec_nxt.mn = M_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.vld <= 1'b0;
    end else begin
      dec_r.vld <= dec_nxt.vld;
    end
    dec_r.mn <= dec_nxt.mn;     dec_r.ra <= dec_nxt.ra;     dec_r.rb <= dec_nxt.rb;
    dec_r.imm <= dec_nxt.imm;   dec_r.io <= dec_nxt.io;     dec_r.bit_i <= dec_nxt.bit_i;
    dec_r.rel <= dec_nxt.rel;   dec_r.addr <= dec_nxt.addr; dec_r.ptr <= dec_nxt.ptr;
    dec_r.mode <= dec_nxt.mode; dec_r.brc <= dec_nxt.brc;   dec_r.two <= dec_nxt.two;
  end

  assign dec_o = dec_r;
endmodule

FILE: sv/mcu_instruction_decoder.sv
// Pipeline from start to out_valid: classify, decode, output register.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Each stage is a fixed register step; results leave as one-cycle strobes.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
// Top level: depends on mid_pkg, mid_classify, mid_decode and the defines header.
`include "mcu_instruction_decoder_defines.svh"
module mcu_instruction_decoder import mid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_instruction_word,
  input  logic [15:0]        in_second_word,
  output logic               out_valid,
  output logic [6:0]         out_mnemonic,
  output logic [4:0]         out_reg_a,
  output logic [4:0]         out_reg_b,
  output logic [7:0]         out_immediate,
  output logic [5:0]         out_io_address,
  output logic [2:0]         out_bit_index,
  output logic signed [11:0] out_rel_offset,
  output logic [22:0]        out_long_address,
  output logic [1:0]         out_pointer_reg,
  output logic [1:0]         out_pointer_mode,
  output logic               out_branch_if_clear,
  output logic               out_two_words
);
  cls_t cls;
  dec_t dec;
  dec_t out_r;

  assign busy = 1'b0;

  mid_classify u_cls (
    .clk(clk), .rst_n(rst_n), .vld_i(start & ~busy),
    .w_i(in_instruction_word), .w2_i(in_second_word), .cls_o(cls)
  );

  mid_decode u_dec (.clk(clk), .rst_n(rst_n), .cls_i(cls), .dec_o(dec));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else begin
      out_r.vld <= dec.vld;
    end
    out_r.mn <= dec.mn;     out_r.ra <= dec.ra;     out_r.rb <= dec.rb;
    out_r.imm <= dec.imm;   out_r.io <= dec.io;     out_r.bit_i <= dec.bit_i;
    out_r.rel <= dec.rel;   out_r.addr <= dec.addr; out_r.ptr <= dec.ptr;
    out_r.mode <= dec.mode; out_r.brc <= dec.brc;   out_r.two <= dec.two;
  end

  assign out_valid           = out_r.vld;
  assign out_mnemonic        = out_r.mn;
  assign out_reg_a           = out_r.ra;
  assign out_reg_b           = out_r.rb;
  assign out_immediate       = out_r.imm;
  assign out_io_address      = out_r.io;
  assign out_bit_index       = out_r.bit_i;
  assign out_rel_offset      = out_r.rel;
  assign out_long_address    = out_r.addr;
  assign out_pointer_reg     = out_r.ptr;
  assign out_pointer_mode    = out_r.mode;
  assign out_branch_if_clear = out_r.brc;
  assign out_two_words       = out_r.two;

  `MID_ASSERT_NXT(a_lat, clk, rst_n, start, ##2 out_valid)
  `MID_ASSERT_IMP(a_two, clk, rst_n, out_valid && out_two_words,
    out_mnemonic == M_JMP || out_mnemonic == M_CALL ||
    out_mnemonic == M_LDS || out_mnemonic == M_STS)
  `MID_ASSERT_IMP(a_brc, clk, rst_n, out_valid && out_branch_if_clear,
    out_mnemonic == M_BRBC)
  `MID_ASSERT_IMP(a_inv, clk, rst_n, out_valid && out_mnemonic == M_INVALID,
    out_pointer_reg == P_NONE && !out_two_words)
endmodule
